// File: rtl/page_lcd_framebuffer_defines.svh
`ifndef PAGE_LCD_FRAMEBUFFER_DEFINES_SVH
`define PAGE_LCD_FRAMEBUFFER_DEFINES_SVH
`ifndef SYNTH
`define PLCDFB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plcdfb assertion failed");
`define PLCDFB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plcdfb assertion failed");
`else
`define PLCDFB_ASSERT_IMP(label, ante, cons)
`define PLCDFB_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/plcdfb_pkg.sv
package plcdfb_pkg;

  localparam int ADDR_MAX_W = 12;
  localparam int CO_W       = 7;

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0]      PAGE_CMD       = 8'hB0;
  localparam logic [7:0]      COLH_CMD       = 8'h10;
  localparam logic [CO_W-1:0] COL_OFFSET_RST = 7'd4;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_PIXEL,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_RMW,
    B_READ,
    B_CLEAR
  } bstate_t;

  typedef struct packed {
    logic       accepted;
    logic       valid;
    logic [7:0] data;
    logic       is_cmd;
    logic       last;
  } res_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [2:0]            bitsel;
    logic                  on;
    res_t                  res;
  } entry_t;

endpackage

// File: rtl/plcdfb_front.sv
`include "page_lcd_framebuffer_defines.svh"

module plcdfb_front
  import plcdfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [1:0]      cmd,
  input  logic [7:0]      pixel_x,
  input  logic [7:0]      pixel_y,
  input  logic            pixel_on,
  input  logic [CO_W-1:0] col_offset,
  output logic            push,
  output entry_t          entry
);

  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SW = $clog2(COLUMNS + 3);
  localparam logic [SW-1:0] SLOT_LAST = SW'(COLUMNS + 2);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

  logic [PW-1:0]         page_r, page_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic                  x_ok, y_ok, wrap;
  logic [ADDR_MAX_W-1:0] pix_addr, tick_addr;

  assign x_ok = {1'b0, pixel_x} < 9'(COLUMNS);
  assign y_ok = {1'b0, pixel_y} < 9'(8 * PAGES);
  assign pix_addr = ADDR_MAX_W'(pixel_y[7:3]) * ADDR_MAX_W'(COLUMNS)
                  + ADDR_MAX_W'(pixel_x);
  assign tick_addr = ADDR_MAX_W'(page_r) * ADDR_MAX_W'(COLUMNS)
                   + ADDR_MAX_W'(slot_r - SW'(3));
  assign wrap = (slot_r == SLOT_LAST);
  assign push = accept;

  always_comb begin
    entry        = '0;
    entry.op     = OP_EMIT;
    entry.bitsel = pixel_y[2:0];
    entry.on     = pixel_on;
    case (cmd)
      CMD_PIXEL: begin
        if (x_ok && y_ok) begin
          entry.op           = OP_PIXEL;
          entry.addr         = pix_addr;
          entry.res.accepted = 1'b1;
        end
      end
      CMD_CLEAR: begin
        entry.op           = OP_CLEAR;
        entry.res.accepted = 1'b1;
      end
      CMD_TICK: begin
        entry.res.accepted = 1'b1;
        entry.res.valid    = 1'b1;
        entry.res.last     = wrap && (page_r == PAGE_LAST);
        if (slot_r == SW'(0)) begin
          entry.res.data   = PAGE_CMD + 8'(page_r);
          entry.res.is_cmd = 1'b1;
        end else if (slot_r == SW'(1)) begin
          entry.res.data   = COLH_CMD | {5'b0, col_offset[6:4]};
          entry.res.is_cmd = 1'b1;
        end else if (slot_r == SW'(2)) begin
          entry.res.data   = {4'b0, col_offset[3:0]};
          entry.res.is_cmd = 1'b1;
        end else begin
          entry.op   = OP_READ;
          entry.addr = tick_addr;
        end
      end
      default: begin
        entry.op = OP_EMIT;
      end
    endcase
  end

  always_comb begin
    page_nxt = page_r;
    slot_nxt = slot_r;
    if (accept && (cmd == CMD_TICK)) begin
      if (wrap) begin
        slot_nxt = '0;
        page_nxt = (page_r == PAGE_LAST) ? '0 : page_r + PW'(1);
      end else begin
        slot_nxt = slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      slot_r <= '0;
    end else begin
      page_r <= page_nxt;
      slot_r <= slot_nxt;
    end
  end

  `PLCDFB_ASSERT_IMP(a_slot_range, 1'b1, slot_r <= SLOT_LAST)

endmodule

// File: rtl/plcdfb_queue.sv
`include "page_lcd_framebuffer_defines.svh"

module plcdfb_queue
  import plcdfb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t     entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head  = entries_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PLCDFB_ASSERT_IMP(a_no_overflow, push, !full || pop)
  `PLCDFB_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

// File: rtl/plcdfb_back.sv
`include "page_lcd_framebuffer_defines.svh"

module plcdfb_back
  import plcdfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic   clk,
  input  logic   rst_n,
  input  entry_t head,
  input  logic   empty,
  output logic   pop,
  output logic   init_active,
  output logic   res_strobe,
  output res_t   res
);

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

  bstate_t       state_r, state_nxt;
  entry_t        cur_r, cur_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          str_r, str_nxt;
  res_t          res_r, res_nxt;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;
  logic [7:0]    mask;

  assign mask        = 8'b1 << cur_r.bitsel;
  assign init_active = (state_r == B_INIT);
  assign res_strobe  = str_r;
  assign res         = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_INIT, B_CLEAR: begin
        if (sweep_r == SWEEP_LAST) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          case (head.op)
            OP_PIXEL: state_nxt = B_RMW;
            OP_CLEAR: state_nxt = B_CLEAR;
            OP_READ:  state_nxt = B_READ;
            default:  state_nxt = B_IDLE;
          endcase
        end
      end
      B_RMW, B_READ: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cur_r.addr[AW-1:0];
    mem_wd    = 8'h00;
    cur_nxt   = cur_r;
    sweep_nxt = sweep_r;
    str_nxt   = 1'b0;
    res_nxt   = cur_r.res;
    case (state_r)
      B_INIT, B_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_r;
        sweep_nxt = (sweep_r == SWEEP_LAST) ? '0 : sweep_r + AW'(1);
        if ((state_r == B_CLEAR) && (sweep_r == SWEEP_LAST)) begin
          str_nxt = 1'b1;
        end
      end
      B_IDLE: begin
        mem_addr = head.addr[AW-1:0];
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          res_nxt = head.res;
          str_nxt = (head.op == OP_EMIT);
        end
      end
      B_RMW: begin
        mem_we  = 1'b1;
        mem_wd  = cur_r.on ? (rd_q | mask) : (rd_q & ~mask);
        str_nxt = 1'b1;
      end
      B_READ: begin
        res_nxt.data = rd_q;
        str_nxt      = 1'b1;
      end
      default: begin
        str_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      sweep_r <= '0;
      str_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      str_r   <= str_nxt;
    end
  end

  `PLCDFB_ASSERT_NXT(a_rmw_emits, state_r == B_RMW, str_r)
  `PLCDFB_ASSERT_IMP(a_init_quiet, state_r == B_INIT, !str_r && !pop)

endmodule

// File: rtl/page_lcd_framebuffer.sv
// Channel   Ports                                   Handshake
// input     start, busy, in_cmd, in_pixel_*         word taken when start && !busy
// result    out_strobe, out_*                       word valid one cycle, no stall
// config    cfg_we, cfg_wdata                       written when cfg_we
//
// Pixel write: read, then write of one single-port RAM word in the back end.
// Refresh tick: a command word needs no RAM access; a data word takes a RAM read.
// Clear: all COLUMNS*PAGES RAM words zeroed, one RAM word zeroed per cycle.
// After reset all COLUMNS*PAGES RAM words are swept to zero with busy high.
// A 2-entry queue decouples accept from execution; busy rises when it is full.
// Results are registered out of the back end; the receiver cannot stall.
module page_lcd_framebuffer
  import plcdfb_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_cmd,
  input  logic [7:0]      in_pixel_x,
  input  logic [7:0]      in_pixel_y,
  input  logic            in_pixel_on,
  output logic            out_strobe,
  output logic            out_accepted,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_is_command,
  output logic            out_frame_last,
  input  logic            cfg_we,
  input  logic [CO_W-1:0] cfg_wdata
);

  logic [CO_W-1:0] col_offset_r;
  logic            accept;
  logic            push;
  entry_t          push_entry;
  entry_t          head;
  logic            pop, q_full, q_empty, init_active;
  res_t            res;

  assign busy   = q_full || init_active;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_offset_r <= COL_OFFSET_RST;
    end else if (cfg_we) begin
      col_offset_r <= cfg_wdata;
    end
  end

  plcdfb_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_cmd),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .pixel_on   (in_pixel_on),
    .col_offset (col_offset_r),
    .push       (push),
    .entry      (push_entry)
  );

  plcdfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  plcdfb_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .init_active (init_active),
    .res_strobe  (out_strobe),
    .res         (res)
  );

  assign out_accepted   = res.accepted;
  assign out_valid      = res.valid;
  assign out_byte       = res.data;
  assign out_is_command = res.is_cmd;
  assign out_frame_last = res.last;

endmodule
